[hdl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// Cartesian-to-Frenet package
// Shared types, register indexes, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned SqrtRounds  = 32;
  localparam int unsigned DivBits     = 49;

  localparam logic [CfgIdxW-1:0] CfgC0   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgC1   = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgC2   = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgStep = 4'd3;

  localparam logic [16:0] StepReset = 17'd6554;
  localparam logic [39:0] DistBound = 40'd65536000000;
  localparam logic [39:0] DistCap   = 40'hFF_FFFF_FFFF;

  // Datapath micro-operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_BUILD_INIT,
    OP_MUL_YY,
    OP_MUL_C2R,
    OP_MUL_C1Y,
    OP_SUM_X,
    OP_MUL_C2Y,
    OP_SLOPE,
    OP_MUL_SS,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MUL_RS,
    OP_ACC,
    OP_WRITE,
    OP_START_POINT,
    OP_MUL_C2BY,
    OP_MUL_DY,
    OP_DOT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT_LOAD
  } dp_op_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_B_INIT,
    ST_B_YY,
    ST_B_YY_W,
    ST_B_C2A,
    ST_B_C2A_W,
    ST_B_C1Y,
    ST_B_C1Y_W,
    ST_B_SUM,
    ST_B_C2Y,
    ST_B_C2Y_W,
    ST_B_SLOPE,
    ST_B_SS,
    ST_B_SS_W,
    ST_B_SQI,
    ST_B_SQ,
    ST_B_RS,
    ST_B_RS_W,
    ST_B_ACC,
    ST_B_WR,
    ST_P_SRCH,
    ST_P_C2Y,
    ST_P_C2Y_W,
    ST_P_SLOPE,
    ST_P_DY,
    ST_P_DY_W,
    ST_P_DOT,
    ST_P_SS,
    ST_P_SS_W,
    ST_P_SQI,
    ST_P_SQ,
    ST_P_DVI,
    ST_P_DV,
    ST_P_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic cfg_hit;
    logic first_sample;
    logic last_sample;
    logic sqrt_last;
    logic div_last;
    logic search_done;
    logic out_busy;
  } dp_status_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q15.16 product rounding: floor((p + 2^15) / 2^16), then saturation.
  function automatic logic signed [31:0] mulq_rnd(input logic signed [65:0] p);
    logic signed [66:0] t;
    t = 67'(p) + 67'sd32768;
    return sat32(t[66:16]);
  endfunction

endpackage

[hdl/cfp_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 160,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cfp_dp.sv]
// ----------------------------------------------------------------------------
// Cartesian-to-Frenet datapath
// Register file, shared multiplier, square root and divider units, sample
// tables and the pipelined nearest-sample search.
// ----------------------------------------------------------------------------
module cfp_dp #(
  parameter int unsigned SampleCount = 160
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfp_pkg::dp_op_e             op_i,
  output cfp_pkg::dp_status_t         status_o,
  input  logic                        cfg_we_i,
  input  logic [cfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [30:0]                 arc_s_o,
  output logic signed [31:0]          offset_d_o,
  output logic [7:0]                  nearest_index_o
);
  import cfp_pkg::*;

  localparam int unsigned IdxW = (SampleCount > 1) ? $clog2(SampleCount) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SampleCount - 1);

  // Configuration registers.
  logic signed [31:0] c0_q, c1_q, c2_q;
  logic [16:0]        step_q;
  logic               cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_index_i == CfgC0 || cfg_index_i == CfgC1 ||
                                cfg_index_i == CfgC2 || cfg_index_i == CfgStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q   <= '0;
      c1_q   <= '0;
      c2_q   <= '0;
      step_q <= StepReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgC0:   c0_q   <= cfg_data_i;
        CfgC1:   c1_q   <= cfg_data_i;
        CfgC2:   c2_q   <= cfg_data_i;
        CfgStep: step_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Table build registers.
  logic [IdxW-1:0]    bi_q;
  logic signed [31:0] by_q, t_q, x_q, slope_q, rq_q;
  logic [31:0]        s_q;
  logic signed [65:0] prod_q;

  // Search registers.
  logic               sr_run_q;
  logic [IdxW-1:0]    sr_addr_q;
  logic signed [31:0] sr_y_q, px_q, py_q;
  logic               s1_v_q, s2_v_q, s3_v_q, done_q;
  logic [IdxW-1:0]    s1_idx_q, s2_idx_q, s3_idx_q;
  logic signed [31:0] s1_y_q, s2_y_q, s3_y_q;
  logic [31:0]        s2_arc_q, s3_arc_q;
  logic signed [32:0] s2_dx_q, s2_dy_q, s3_dx_q, s3_dy_q;
  logic [63:0]        s3_sqx_q, s3_sqy_q;
  logic [39:0]        best_dist_q;
  logic [IdxW-1:0]    best_idx_q;
  logic signed [31:0] best_y_q;
  logic [31:0]        best_arc_q;
  logic signed [32:0] best_dx_q, best_dy_q;

  // Finishing registers.
  logic signed [32:0] dot_q;
  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;
  logic [5:0]         cnt_q;
  logic [48:0]        num_q, quo_q;
  logic [24:0]        rem_q;

  // Output register.
  logic               out_valid_q;
  logic [30:0]        arc_q;
  logic signed [31:0] offset_q;
  logic [7:0]         nidx_q;

  // Table memories.
  logic [31:0] lat_rd, arc_rd;
  logic        tbl_we;

  assign tbl_we = (op_i == OP_WRITE);

  cfp_ram #(.Width(32), .Depth(SampleCount)) u_lat_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (bi_q),
    .wdata_i (x_q),
    .raddr_i (sr_addr_q),
    .rdata_o (lat_rd)
  );

  cfp_ram #(.Width(32), .Depth(SampleCount)) u_arc_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (bi_q),
    .wdata_i (s_q),
    .raddr_i (sr_addr_q),
    .rdata_o (arc_rd)
  );

  // Shared multiplier operand selection.
  logic signed [32:0] ma, mb;
  logic               mul_en;

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (op_i)
      OP_MUL_YY:   begin ma = 33'(by_q);    mb = 33'(by_q);    end
      OP_MUL_C2R:  begin ma = 33'(c2_q);    mb = 33'(rq_q);    end
      OP_MUL_C1Y:  begin ma = 33'(c1_q);    mb = 33'(by_q);    end
      OP_MUL_C2Y:  begin ma = 33'(c2_q);    mb = 33'(by_q);    end
      OP_MUL_C2BY: begin ma = 33'(c2_q);    mb = 33'(best_y_q); end
      OP_MUL_SS:   begin ma = 33'(slope_q); mb = 33'(slope_q); end
      OP_MUL_RS:   begin
        ma = $signed({8'b0, sq_res_q[24:0]});
        mb = $signed({16'b0, step_q});
      end
      OP_MUL_DY:   begin ma = 33'(sat32(51'(best_dy_q))); mb = 33'(slope_q); end
      default:     mul_en = 1'b0;
    endcase
  end

  // Arithmetic helpers for the single-step operations.
  logic signed [33:0] x_sum, sl_sum;
  logic [32:0]        s_sum;
  logic [32:0]        n2;
  logic [63:0]        sq_trial;
  logic signed [32:0] ndot;
  logic [32:0]        dmag;
  logic [25:0]        dv_trial;
  logic [30:0]        dsat;

  assign x_sum    = 34'(t_q) + 34'(rq_q) + 34'(c0_q);
  assign sl_sum   = 34'($signed({rq_q, 1'b0})) + 34'(c1_q);
  assign s_sum    = 33'(s_q) + 33'(unsigned'(rq_q));
  assign n2       = 33'd65536 + {1'b0, rq_q};
  assign sq_trial = sq_res_q + sq_bit_q;
  assign ndot     = -dot_q;
  assign dmag     = dot_q[32] ? ndot : dot_q;
  assign dv_trial = {rem_q, num_q[48]};
  assign dsat     = (quo_q > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo_q[30:0];

  always_ff @(posedge clk_i) begin
    rq_q <= mulq_rnd(prod_q);
    if (mul_en) begin
      prod_q <= ma * mb;
    end
    case (op_i)
      OP_BUILD_INIT: begin
        bi_q <= '0;
        by_q <= '0;
        s_q  <= '0;
      end
      OP_MUL_C1Y:   t_q     <= rq_q;
      OP_SUM_X:     x_q     <= sat32(51'(x_sum));
      OP_SLOPE:     slope_q <= sat32(51'(sl_sum));
      OP_ACC:       s_q     <= (s_sum > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : s_sum[31:0];
      OP_WRITE: begin
        bi_q <= bi_q + 1'b1;
        by_q <= by_q + 32'(step_q);
      end
      OP_SQRT_INIT: begin
        sq_v_q   <= {15'b0, n2, 16'b0};
        sq_res_q <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
        cnt_q    <= '0;
      end
      OP_SQRT_STEP: begin
        if (sq_v_q >= sq_trial) begin
          sq_v_q   <= sq_v_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        cnt_q    <= cnt_q + 1'b1;
      end
      OP_START_POINT: begin
        px_q <= point_x_i;
        py_q <= point_y_i;
      end
      OP_DOT: dot_q <= 33'(sat32(51'(best_dx_q))) - 33'(rq_q);
      OP_DIV_INIT: begin
        num_q <= {dmag, 16'b0} + 49'(sq_res_q[24:1]);
        quo_q <= '0;
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_DIV_STEP: begin
        num_q <= {num_q[47:0], 1'b0};
        if (dv_trial >= {1'b0, sq_res_q[24:0]}) begin
          rem_q <= 25'(dv_trial - {1'b0, sq_res_q[24:0]});
          quo_q <= {quo_q[47:0], 1'b1};
        end else begin
          rem_q <= dv_trial[24:0];
          quo_q <= {quo_q[47:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      OP_OUT_LOAD: begin
        arc_q    <= best_arc_q[30:0];
        offset_q <= best_dx_q[32] ? -$signed({1'b0, dsat}) : $signed({1'b0, dsat});
        nidx_q   <= 8'({8'b0, best_idx_q});
      end
      default: ;
    endcase
  end

  // Search pipeline: issue, table read, difference, square, compare.
  logic signed [32:0] nx, ny;
  logic [31:0]        ux, uy;
  logic [48:0]        dsum;
  logic [39:0]        dist_sat, cur;
  logic               take;

  assign nx       = -s2_dx_q;
  assign ny       = -s2_dy_q;
  assign ux       = s2_dx_q[32] ? nx[31:0] : s2_dx_q[31:0];
  assign uy       = s2_dy_q[32] ? ny[31:0] : s2_dy_q[31:0];
  assign dsum     = 49'(s3_sqx_q[63:16]) + 49'(s3_sqy_q[63:16]);
  assign dist_sat = (dsum > 49'(DistCap)) ? DistCap : dsum[39:0];
  assign cur      = (s3_idx_q == '0) ? DistBound : best_dist_q;
  assign take     = dist_sat < cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_run_q <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (op_i == OP_START_POINT) begin
        sr_run_q <= 1'b1;
      end else if (sr_run_q && sr_addr_q == LastIdx) begin
        sr_run_q <= 1'b0;
      end
      s1_v_q <= sr_run_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      done_q <= s3_v_q && (s3_idx_q == LastIdx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_START_POINT) begin
      sr_addr_q <= '0;
      sr_y_q    <= '0;
    end else if (sr_run_q) begin
      sr_addr_q <= sr_addr_q + 1'b1;
      sr_y_q    <= sr_y_q + 32'(step_q);
    end
    s1_idx_q <= sr_addr_q;
    s1_y_q   <= sr_y_q;
    s2_idx_q <= s1_idx_q;
    s2_y_q   <= s1_y_q;
    s2_arc_q <= arc_rd;
    s2_dx_q  <= 33'(px_q) - 33'($signed(lat_rd));
    s2_dy_q  <= 33'(py_q) - 33'(s1_y_q);
    s3_idx_q <= s2_idx_q;
    s3_y_q   <= s2_y_q;
    s3_arc_q <= s2_arc_q;
    s3_dx_q  <= s2_dx_q;
    s3_dy_q  <= s2_dy_q;
    s3_sqx_q <= 64'(ux) * 64'(ux);
    s3_sqy_q <= 64'(uy) * 64'(uy);
    if (s3_v_q) begin
      best_dist_q <= take ? dist_sat : cur;
      if (take || s3_idx_q == '0) begin
        best_idx_q <= s3_idx_q;
        best_y_q   <= s3_y_q;
        best_arc_q <= s3_arc_q;
        best_dx_q  <= s3_dx_q;
        best_dy_q  <= s3_dy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_OUT_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.cfg_hit      = cfg_hit;
  assign status_o.first_sample = (bi_q == '0);
  assign status_o.last_sample  = (bi_q == LastIdx);
  assign status_o.sqrt_last    = (cnt_q == 6'(SqrtRounds - 1));
  assign status_o.div_last     = (cnt_q == 6'(DivBits - 1));
  assign status_o.search_done  = done_q;
  assign status_o.out_busy     = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign arc_s_o         = arc_q;
  assign offset_d_o      = offset_q;
  assign nearest_index_o = nidx_q;

endmodule

[hdl/cfp_ctrl.sv]
// ----------------------------------------------------------------------------
// Cartesian-to-Frenet controller
// Sequences table rebuilds and point conversions through datapath operations.
// ----------------------------------------------------------------------------
module cfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                in_valid_i,
  input  cfp_pkg::dp_status_t status_i,
  output logic                cfg_ready_o,
  output logic                in_ready_o,
  output cfp_pkg::dp_op_e     op_o
);
  import cfp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    cfg_ready_o = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (status_i.cfg_hit) begin
          state_d = ST_B_INIT;
        end else if (in_valid_i && !cfg_valid_i) begin
          op_o    = OP_START_POINT;
          state_d = ST_P_SRCH;
        end
      end
      ST_B_INIT:  begin op_o = OP_BUILD_INIT; state_d = ST_B_YY;    end
      ST_B_YY:    begin op_o = OP_MUL_YY;     state_d = ST_B_YY_W;  end
      ST_B_YY_W:  state_d = ST_B_C2A;
      ST_B_C2A:   begin op_o = OP_MUL_C2R;    state_d = ST_B_C2A_W; end
      ST_B_C2A_W: state_d = ST_B_C1Y;
      ST_B_C1Y:   begin op_o = OP_MUL_C1Y;    state_d = ST_B_C1Y_W; end
      ST_B_C1Y_W: state_d = ST_B_SUM;
      ST_B_SUM: begin
        op_o    = OP_SUM_X;
        state_d = status_i.first_sample ? ST_B_WR : ST_B_C2Y;
      end
      ST_B_C2Y:   begin op_o = OP_MUL_C2Y;    state_d = ST_B_C2Y_W; end
      ST_B_C2Y_W: state_d = ST_B_SLOPE;
      ST_B_SLOPE: begin op_o = OP_SLOPE;      state_d = ST_B_SS;    end
      ST_B_SS:    begin op_o = OP_MUL_SS;     state_d = ST_B_SS_W;  end
      ST_B_SS_W:  state_d = ST_B_SQI;
      ST_B_SQI:   begin op_o = OP_SQRT_INIT;  state_d = ST_B_SQ;    end
      ST_B_SQ: begin
        op_o = OP_SQRT_STEP;
        if (status_i.sqrt_last) begin
          state_d = ST_B_RS;
        end
      end
      ST_B_RS:    begin op_o = OP_MUL_RS;     state_d = ST_B_RS_W;  end
      ST_B_RS_W:  state_d = ST_B_ACC;
      ST_B_ACC:   begin op_o = OP_ACC;        state_d = ST_B_WR;    end
      ST_B_WR: begin
        op_o    = OP_WRITE;
        state_d = status_i.last_sample ? ST_IDLE : ST_B_YY;
      end
      ST_P_SRCH: begin
        if (status_i.search_done) begin
          state_d = ST_P_C2Y;
        end
      end
      ST_P_C2Y:   begin op_o = OP_MUL_C2BY;   state_d = ST_P_C2Y_W; end
      ST_P_C2Y_W: state_d = ST_P_SLOPE;
      ST_P_SLOPE: begin op_o = OP_SLOPE;      state_d = ST_P_DY;    end
      ST_P_DY:    begin op_o = OP_MUL_DY;     state_d = ST_P_DY_W;  end
      ST_P_DY_W:  state_d = ST_P_DOT;
      ST_P_DOT:   begin op_o = OP_DOT;        state_d = ST_P_SS;    end
      ST_P_SS:    begin op_o = OP_MUL_SS;     state_d = ST_P_SS_W;  end
      ST_P_SS_W:  state_d = ST_P_SQI;
      ST_P_SQI:   begin op_o = OP_SQRT_INIT;  state_d = ST_P_SQ;    end
      ST_P_SQ: begin
        op_o = OP_SQRT_STEP;
        if (status_i.sqrt_last) begin
          state_d = ST_P_DVI;
        end
      end
      ST_P_DVI:   begin op_o = OP_DIV_INIT;   state_d = ST_P_DV;    end
      ST_P_DV: begin
        op_o = OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = ST_P_OUT;
        end
      end
      ST_P_OUT: begin
        if (!status_i.out_busy) begin
          op_o    = OP_OUT_LOAD;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hdl/cartesian_to_frenet_point.sv]
// ----------------------------------------------------------------------------
// Cartesian-to-Frenet point converter
// Matches each point to the nearest sample of a quadratic reference lane and
// returns arc length, signed normal offset and sample index.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Word
// cfg       in         cfg_valid/cfg_ready   register index and 32-bit data
// in        in         in_valid/in_ready     point_x, point_y (Q15.16)
// out       out        out_valid/out_ready   arc_s, offset_d, nearest_index
//
// For each point the search walks the sample tables one entry per cycle
// through a pipeline, then the slope, a 32-round square root and a 49-bit
// restoring divide finish the word. A write to a known register rebuilds
// the tables one sample at a time, with a 32-round square root for each
// arc increment; no point is taken during the rebuild. Reset clears control
// state and loads the register defaults; the tables hold nothing until the
// first write.
// A finished word waits in the output register while the next point is taken.
//
module cartesian_to_frenet_point #(
  parameter int unsigned SAMPLE_COUNT = 160
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [30:0]                 arc_s_o,
  output logic signed [31:0]          offset_d_o,
  output logic [7:0]                  nearest_index_o
);
  import cfp_pkg::*;

  dp_op_e     op;
  dp_status_t status;
  logic       cfg_we;

  // A write lands in the register file whenever the handshake completes;
  // the datapath flags whether the index names a real register.
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  // The controller owns all sequencing; the datapath only executes the
  // operation it is handed in each cycle and reports its counters.
  cfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .in_valid_i  (in_valid_i),
    .status_i    (status),
    .cfg_ready_o (cfg_ready_o),
    .in_ready_o  (in_ready_o),
    .op_o        (op)
  );

  cfp_dp #(.SampleCount(SAMPLE_COUNT)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .status_o        (status),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .arc_s_o         (arc_s_o),
    .offset_d_o      (offset_d_o),
    .nearest_index_o (nearest_index_o)
  );

endmodule

[hdl/cfp_checker.sv]
// ----------------------------------------------------------------------------
// Cartesian-to-Frenet port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module cfp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [cfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [30:0]                 arc_s_o,
  input logic signed [31:0]          offset_d_o,
  input logic [7:0]                  nearest_index_o
);
  import cfp_pkg::*;

  // A stalled word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(arc_s_o) &&
    $stable(offset_d_o) && $stable(nearest_index_o))
    else $error("output word changed while stalled");

  // Points are only taken when configuration could also be taken.
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> cfg_ready_o)
    else $error("point ready outside idle");

  // A taken point keeps the block busy on the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !cfg_ready_o)
    else $error("block ready right after taking a point");

  // A write to a known register starts a rebuild.
  a_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgC0 || cfg_index_i == CfgC1 ||
    cfg_index_i == CfgC2 || cfg_index_i == CfgStep) |=> !in_ready_o && !cfg_ready_o)
    else $error("no table rebuild after register write");

  // No result can appear the cycle after a point is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind cartesian_to_frenet_point cfp_checker u_cfp_checker (.*);
